>>> hdl/rpwn_pkg.sv
// Shared types and constants for the RC pulse width normalizer.
// Standalone package; every other file in hdl/ imports it.
package rpwn_pkg;

    localparam int TIME_W      = 16;
    localparam int LEVEL_W     = 17;
    localparam int ACTION_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_STEPS   = 16;
    localparam int STEP_CNT_W  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;

    localparam logic [TIME_W-1:0] RST_ACCEPT_LOW  = 16'd900;
    localparam logic [TIME_W-1:0] RST_ACCEPT_HIGH = 16'd2200;
    localparam logic [TIME_W-1:0] RST_RANGE_MIN   = 16'd1000;
    localparam logic [TIME_W-1:0] RST_RANGE_MAX   = 16'd2000;
    localparam logic [TIME_W-1:0] RST_TIMEOUT     = 16'd200;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WIDTH  = 2'd0,
        ACT_PERIOD = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED     = 3'd0,
        CFG_ACCEPT_LOW  = 3'd1,
        CFG_ACCEPT_HIGH = 3'd2,
        CFG_RANGE_MIN   = 3'd3,
        CFG_RANGE_MAX   = 3'd4,
        CFG_REVERSED    = 3'd5,
        CFG_TIMEOUT     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic              enabled;
        logic [TIME_W-1:0] accept_low;
        logic [TIME_W-1:0] accept_high;
        logic [TIME_W-1:0] range_min;
        logic [TIME_W-1:0] range_max;
        logic              reversed;
        logic [TIME_W-1:0] timeout_ticks;
    } cfg_t;

    // Snapshot of the stored width and period after one request.
    typedef struct packed {
        logic [TIME_W-1:0] pulse_width;
        logic [TIME_W-1:0] period;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_CALC = 3'b010,
        BK_OUT  = 3'b100
    } back_state_t;

endpackage

>>> hdl/rc_pulse_width_normalizer_top.sv
// Top level of the RC pulse width normalizer: configuration registers, front end,
// job queue and level unit. Depends on rpwn_pkg, rpwn_front, rpwn_queue, rpwn_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_action, s_captured_time
//   m_        out        m_valid/m_ready    m_pulse_width, m_period, m_level
//   cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// A request updates the state in the cycle it is accepted; the level unit then
// takes the job in its idle state and, for a level strictly between 0 and 1, runs
// the divider, then shows the result; it takes no new job until that is taken.
// aresetn is synchronous and active low and restores the register defaults.
// A stalled result holds the level unit; the front end keeps accepting until the
// two-entry queue is full.
module rc_pulse_width_normalizer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rpwn_pkg::ACTION_W-1:0]  s_action,
    input  logic [rpwn_pkg::TIME_W-1:0]    s_captured_time,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rpwn_pkg::TIME_W-1:0]    m_pulse_width,
    output logic [rpwn_pkg::TIME_W-1:0]    m_period,
    output logic [rpwn_pkg::LEVEL_W-1:0]   m_level,
    input  logic                           cfg_wr_en,
    input  logic [rpwn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpwn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rpwn_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head_job;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENABLED:     cfg_next.enabled       = cfg_wdata[0];
                CFG_ACCEPT_LOW:  cfg_next.accept_low    = cfg_wdata;
                CFG_ACCEPT_HIGH: cfg_next.accept_high   = cfg_wdata;
                CFG_RANGE_MIN:   cfg_next.range_min     = cfg_wdata;
                CFG_RANGE_MAX:   cfg_next.range_max     = cfg_wdata;
                CFG_REVERSED:    cfg_next.reversed      = cfg_wdata[0];
                CFG_TIMEOUT:     cfg_next.timeout_ticks = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled       <= 1'b0;
            cfg_reg.accept_low    <= RST_ACCEPT_LOW;
            cfg_reg.accept_high   <= RST_ACCEPT_HIGH;
            cfg_reg.range_min     <= RST_RANGE_MIN;
            cfg_reg.range_max     <= RST_RANGE_MAX;
            cfg_reg.reversed      <= 1'b0;
            cfg_reg.timeout_ticks <= RST_TIMEOUT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rpwn_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_captured_time (s_captured_time),
        .q_full          (q_full),
        .push            (push),
        .push_job        (push_job)
    );

    rpwn_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    rpwn_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pulse_width (m_pulse_width),
        .m_period      (m_period),
        .m_level       (m_level)
    );

endmodule

>>> hdl/rpwn_front.sv
// Front end: accepts requests, updates the width, period and loss timer state,
// and pushes a snapshot job into the queue. Depends on rpwn_pkg.
module rpwn_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rpwn_pkg::cfg_t                 cfg,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rpwn_pkg::ACTION_W-1:0]  s_action,
    input  logic [rpwn_pkg::TIME_W-1:0]    s_captured_time,
    input  logic                           q_full,
    output logic                           push,
    output rpwn_pkg::job_t                 push_job
);
    import rpwn_pkg::*;

    logic [TIME_W-1:0] width_reg, width_next;
    logic [TIME_W-1:0] period_reg, period_next;
    logic [TIME_W-1:0] count_reg, count_next;
    logic              armed_reg, armed_next;
    logic              accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign push    = accept;

    always_comb begin
        width_next  = width_reg;
        period_next = period_reg;
        count_next  = count_reg;
        armed_next  = armed_reg;
        if (accept) begin
            case (s_action)
                ACT_WIDTH: begin
                    if (s_captured_time > cfg.accept_low && s_captured_time < cfg.accept_high) begin
                        width_next = s_captured_time;
                    end
                    // Any width event re-arms the timer, accepted or not.
                    count_next = cfg.timeout_ticks;
                    armed_next = 1'b1;
                end
                ACT_PERIOD: begin
                    period_next = s_captured_time;
                end
                ACT_TICK: begin
                    if (armed_reg) begin
                        if (count_reg <= 16'd1) begin
                            count_next = '0;
                            armed_next = 1'b0;
                            width_next = '0;
                        end else begin
                            count_next = count_reg - 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign push_job.pulse_width = width_next;
    assign push_job.period      = period_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            period_reg <= '0;
            count_reg  <= '0;
            armed_reg  <= 1'b0;
        end else begin
            width_reg  <= width_next;
            period_reg <= period_next;
            count_reg  <= count_next;
            armed_reg  <= armed_next;
        end
    end

endmodule

>>> hdl/rpwn_queue.sv
// Two-entry job queue between the front end and the level unit.
// Depends on rpwn_pkg.
module rpwn_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rpwn_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rpwn_pkg::job_t head_job
);
    import rpwn_pkg::*;

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hdl/rpwn_back.sv
// Back end: takes jobs from the queue, works out the normalized level with a
// bit-per-cycle restoring divider and holds the result. Depends on rpwn_pkg.
module rpwn_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rpwn_pkg::cfg_t                cfg,
    input  logic                          head_valid,
    input  rpwn_pkg::job_t                head_job,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rpwn_pkg::TIME_W-1:0]   m_pulse_width,
    output logic [rpwn_pkg::TIME_W-1:0]   m_period,
    output logic [rpwn_pkg::LEVEL_W-1:0]  m_level
);
    import rpwn_pkg::*;

    back_state_t           state_reg, state_next;
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]     span_reg, span_next;
    logic [TIME_W-1:0]     quot_reg, quot_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]     pulse_reg, pulse_next;
    logic [TIME_W-1:0]     period_reg, period_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;

    logic [TIME_W-1:0]     w;
    logic [TIME_W-1:0]     span;
    logic [TIME_W-1:0]     num;
    logic                  range_ok;
    logic                  below;
    logic [TIME_W:0]       rem_dbl;
    logic [TIME_W:0]       rem_diff;
    logic                  ge;

    assign w        = head_job.pulse_width;
    assign range_ok = cfg.range_max > cfg.range_min;
    assign span     = cfg.range_max - cfg.range_min;
    assign below    = cfg.reversed ? (w >= cfg.range_max) : (w <= cfg.range_min);
    assign num      = cfg.reversed ? (cfg.range_max - w) : (w - cfg.range_min);

    // The remainder stays below the span, so doubling it fits in one extra bit.
    assign rem_dbl  = {rem_reg, 1'b0};
    assign rem_diff = rem_dbl - {1'b0, span_reg};
    assign ge       = rem_dbl >= {1'b0, span_reg};

    assign pop     = (state_reg == BK_IDLE) && head_valid;
    assign m_valid = (state_reg == BK_OUT);
    assign m_pulse_width = pulse_reg;
    assign m_period      = period_reg;
    assign m_level       = level_reg;

    always_comb begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        span_next   = span_reg;
        quot_next   = quot_reg;
        cnt_next    = cnt_reg;
        pulse_next  = pulse_reg;
        period_next = period_reg;
        level_next  = level_reg;
        case (state_reg)
            BK_IDLE: begin
                if (head_valid) begin
                    period_next = head_job.period;
                    pulse_next  = cfg.enabled ? w : '0;
                    if (!cfg.enabled || !range_ok || below) begin
                        level_next = '0;
                        state_next = BK_OUT;
                    end else if (num >= span) begin
                        level_next = LEVEL_ONE;
                        state_next = BK_OUT;
                    end else begin
                        rem_next   = num;
                        span_next  = span;
                        quot_next  = '0;
                        cnt_next   = '0;
                        state_next = BK_CALC;
                    end
                end
            end
            BK_CALC: begin
                rem_next  = ge ? rem_diff[TIME_W-1:0] : rem_dbl[TIME_W-1:0];
                quot_next = {quot_reg[TIME_W-2:0], ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    level_next = {1'b0, quot_reg[TIME_W-2:0], ge};
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        span_reg   <= span_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        pulse_reg  <= pulse_next;
        period_reg <= period_next;
        level_reg  <= level_next;
    end

endmodule
